[hdl/tpf_pkg.sv]
package tpf_pkg;

   // video memory size in bytes; must be a power of two
   localparam int unsigned MEM_BYTES_DEFAULT = 65536;

   // field widths
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned COORD_W     = 10;
   localparam int unsigned SIZE_W      = 8;
   localparam int unsigned BASE_W      = 16;
   localparam int unsigned HOST_ADDR_W = 16;
   localparam int unsigned PAL_W       = 2;
   localparam int unsigned NIB_W       = 4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_BASE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_TILES  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT_TILES = 2'd2;

   // register reset values
   localparam logic [BASE_W-1:0] TABLE_BASE_RESET   = 16'd0;
   localparam logic [SIZE_W-1:0] WIDTH_TILES_RESET  = 8'd64;
   localparam logic [SIZE_W-1:0] HEIGHT_TILES_RESET = 8'd32;

   // request modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

endpackage

[hdl/tilemap_plane_pixel_fetch.sv]
// Tile map plane pixel fetch. Each beat on the req_ side is either a byte
// write into video memory (req_mode = 0) or a query of one plane pixel
// (req_mode = 1). busy is always low: a beat is taken on every clock at which
// start is high, so a raster scan can issue one pixel per clock. A query
// answers via the A/B/C and response registers (rsp_valid high for one clock,
// the beat is gone at the end of that clock); the receiver cannot stall and
// writes give no answer. The latency comes from two dependent reads of the
// video memory: the 16-bit name table entry, then the tile byte it points to.
// Video memory is split into an even-byte and an odd-byte bank so the two
// entry bytes come out of one read at any alignment. A write lands in the
// cycle after it is taken, so it is seen by every later query and never by an
// earlier one. MEM_BYTES must be a power of two; all addresses wrap at it.
// Bytes read before they are written return undefined data.
// Configuration (csr_) may be written only while no query is in flight.
module tilemap_plane_pixel_fetch #(
   parameter int unsigned MEM_BYTES = tpf_pkg::MEM_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_write_en,
   input  logic [tpf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tpf_pkg::CSR_DATA_W-1:0]      csr_write_data,
   // request
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_mode,
   input  logic [tpf_pkg::HOST_ADDR_W-1:0]     req_mem_address,
   input  logic [7:0]                          req_mem_data,
   input  logic [tpf_pkg::COORD_W-1:0]         req_query_x,
   input  logic [tpf_pkg::COORD_W-1:0]         req_query_y,
   // response
   output logic                                rsp_valid,
   output logic [tpf_pkg::COORD_W-1:0]         rsp_out_x,
   output logic [tpf_pkg::COORD_W-1:0]         rsp_out_y,
   output logic [tpf_pkg::PAL_W-1:0]           rsp_palette_line,
   output logic [tpf_pkg::NIB_W-1:0]           rsp_color_index,
   output logic                                rsp_opaque,
   output logic                                rsp_in_range
);

   localparam int unsigned AW         = $clog2(MEM_BYTES);
   localparam int unsigned BANK_AW    = AW - 1;
   localparam int unsigned BANK_DEPTH = MEM_BYTES / 2;
   localparam int unsigned CW         = tpf_pkg::COORD_W;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [tpf_pkg::BASE_W-1:0] table_base_ff,   table_base_in;
   logic [tpf_pkg::SIZE_W-1:0] width_tiles_ff,  width_tiles_in;
   logic [tpf_pkg::SIZE_W-1:0] height_tiles_ff, height_tiles_in;

   always_comb begin
      table_base_in   = table_base_ff;
      width_tiles_in  = width_tiles_ff;
      height_tiles_in = height_tiles_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            tpf_pkg::CSR_TABLE_BASE:   table_base_in   = csr_write_data;
            tpf_pkg::CSR_WIDTH_TILES:  width_tiles_in  = csr_write_data[tpf_pkg::SIZE_W-1:0];
            tpf_pkg::CSR_HEIGHT_TILES: height_tiles_in = csr_write_data[tpf_pkg::SIZE_W-1:0];
            default: ;  // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_base_ff   <= tpf_pkg::TABLE_BASE_RESET;
         width_tiles_ff  <= tpf_pkg::WIDTH_TILES_RESET;
         height_tiles_ff <= tpf_pkg::HEIGHT_TILES_RESET;
      end else begin
         table_base_ff   <= table_base_in;
         width_tiles_ff  <= width_tiles_in;
         height_tiles_ff <= height_tiles_in;
      end
   end

   // ---------------------------------------------------------------------
   // Request decode. Never stalls.
   // ---------------------------------------------------------------------
   logic accept, query_beat, write_beat;

   assign busy       = 1'b0;
   assign accept     = start && !busy;
   assign query_beat = accept && (req_mode == tpf_pkg::MODE_QUERY);
   assign write_beat = accept && (req_mode == tpf_pkg::MODE_WRITE);

   // Write staging: the write lands in the cycle after its beat. A query taken
   // on the clock before reads its tile byte on that same edge and gets the
   // old byte; without the delay it would see the new one.
   logic              wr_valid_ff;
   logic [AW-1:0]     wr_addr_ff;
   logic [7:0]        wr_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
      end else begin
         wr_valid_ff <= write_beat;
      end
      wr_addr_ff <= req_mem_address[AW-1:0];
      wr_data_ff <= req_mem_data;
   end

   // ---------------------------------------------------------------------
   // Stage A: range check and cell row product
   // ---------------------------------------------------------------------
   logic                 a_valid_ff;
   logic [CW-1:0]        a_x_ff, a_y_ff;
   logic                 a_in_range_ff, a_in_range_in;
   logic [14:0]          a_row_cell_ff, a_row_cell_in;

   assign a_in_range_in = ({1'b0, req_query_x} < {width_tiles_ff, 3'b000}) &&
                          ({1'b0, req_query_y} < {height_tiles_ff, 3'b000});
   assign a_row_cell_in = 15'(req_query_y[CW-1:3]) * 15'(width_tiles_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= query_beat;
      end
      a_x_ff        <= req_query_x;
      a_y_ff        <= req_query_y;
      a_in_range_ff <= a_in_range_in;
      a_row_cell_ff <= a_row_cell_in;
   end

   // entry address and its successor, bank-split
   logic [15:0]          a_cell;
   logic [16:0]          a_entry_sum;
   logic [AW-1:0]        a_entry_addr, a_entry_next;
   logic [BANK_AW-1:0]   even_idx_a, odd_idx_a;

   assign a_cell       = {1'b0, a_row_cell_ff} + 16'(a_x_ff[CW-1:3]);
   assign a_entry_sum  = 17'(table_base_ff) + {a_cell, 1'b0};
   assign a_entry_addr = a_entry_sum[AW-1:0];
   assign a_entry_next = a_entry_addr + AW'(1);
   // odd entry: high byte in odd bank, low byte in even bank one row up
   assign odd_idx_a    = a_entry_addr[AW-1:1];
   assign even_idx_a   = a_entry_addr[0] ? a_entry_next[AW-1:1] : a_entry_addr[AW-1:1];

   // ---------------------------------------------------------------------
   // Stage B: entry bytes back, form tile byte address
   // ---------------------------------------------------------------------
   logic                 b_valid_ff;
   logic [CW-1:0]        b_x_ff, b_y_ff;
   logic                 b_in_range_ff;
   logic                 b_swap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_x_ff        <= a_x_ff;
      b_y_ff        <= a_y_ff;
      b_in_range_ff <= a_in_range_ff;
      b_swap_ff     <= a_entry_addr[0];
   end

   logic [7:0]           even_rd_a_ff, odd_rd_a_ff;
   logic [7:0]           even_rd_b_ff, odd_rd_b_ff;
   logic [7:0]           b_entry_hi, b_entry_lo;
   logic [10:0]          b_tile;
   logic [15:0]          b_tile_full;
   logic [AW-1:0]        b_tile_addr;
   logic [BANK_AW-1:0]   tile_idx_b;

   assign b_entry_hi  = b_swap_ff ? odd_rd_a_ff  : even_rd_a_ff;
   assign b_entry_lo  = b_swap_ff ? even_rd_a_ff : odd_rd_a_ff;
   assign b_tile      = {b_entry_hi[2:0], b_entry_lo};
   // tile*32 + row*4 + col/2
   assign b_tile_full = {b_tile, b_y_ff[2:0], b_x_ff[2:1]};
   assign b_tile_addr = b_tile_full[AW-1:0];
   assign tile_idx_b  = b_tile_addr[AW-1:1];

   // ---------------------------------------------------------------------
   // Video memory banks: one write, two registered reads each
   // ---------------------------------------------------------------------
   logic [7:0] even_bank [BANK_DEPTH];
   logic [7:0] odd_bank  [BANK_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_valid_ff && !wr_addr_ff[0]) begin
         even_bank[wr_addr_ff[AW-1:1]] <= wr_data_ff;
      end
      even_rd_a_ff <= even_bank[even_idx_a];
      even_rd_b_ff <= even_bank[tile_idx_b];
   end

   always_ff @(posedge clock) begin
      if (wr_valid_ff && wr_addr_ff[0]) begin
         odd_bank[wr_addr_ff[AW-1:1]] <= wr_data_ff;
      end
      odd_rd_a_ff <= odd_bank[odd_idx_a];
      odd_rd_b_ff <= odd_bank[tile_idx_b];
   end

   // ---------------------------------------------------------------------
   // Stage C: tile byte back, pick the nibble
   // ---------------------------------------------------------------------
   logic                  c_valid_ff;
   logic [CW-1:0]         c_x_ff, c_y_ff;
   logic                  c_in_range_ff;
   logic                  c_odd_byte_ff;
   logic [tpf_pkg::PAL_W-1:0] c_pal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      c_x_ff        <= b_x_ff;
      c_y_ff        <= b_y_ff;
      c_in_range_ff <= b_in_range_ff;
      c_odd_byte_ff <= b_tile_addr[0];
      c_pal_ff      <= b_entry_hi[6:5];
   end

   logic [7:0]                 c_tile_byte;
   logic [tpf_pkg::NIB_W-1:0]  c_nibble;

   assign c_tile_byte = c_odd_byte_ff ? odd_rd_b_ff : even_rd_b_ff;
   // even column: high nibble
   assign c_nibble    = c_x_ff[0] ? c_tile_byte[3:0] : c_tile_byte[7:4];

   // ---------------------------------------------------------------------
   // Response register; out-of-plane pixels report zeros
   // ---------------------------------------------------------------------
   logic                       rsp_valid_ff;
   logic [CW-1:0]              rsp_x_ff, rsp_y_ff;
   logic [tpf_pkg::PAL_W-1:0]  rsp_pal_ff;
   logic [tpf_pkg::NIB_W-1:0]  rsp_color_ff, rsp_color_in;
   logic                       rsp_opaque_ff;
   logic                       rsp_in_range_ff;

   assign rsp_color_in = c_in_range_ff ? c_nibble : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= c_valid_ff;
      end
      rsp_x_ff        <= c_x_ff;
      rsp_y_ff        <= c_y_ff;
      rsp_pal_ff      <= c_in_range_ff ? c_pal_ff : '0;
      rsp_color_ff    <= rsp_color_in;
      rsp_opaque_ff   <= (rsp_color_in != '0);
      rsp_in_range_ff <= c_in_range_ff;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_x        = rsp_x_ff;
   assign rsp_out_y        = rsp_y_ff;
   assign rsp_palette_line = rsp_pal_ff;
   assign rsp_color_index  = rsp_color_ff;
   assign rsp_opaque       = rsp_opaque_ff;
   assign rsp_in_range     = rsp_in_range_ff;

endmodule

[tb/sv/tpf_checker.sv]
module tpf_checker #(
   parameter int unsigned MEM_BYTES = tpf_pkg::MEM_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [tpf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tpf_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                start,
   input  logic                                busy,
   input  logic                                req_mode,
   input  logic [tpf_pkg::HOST_ADDR_W-1:0]     req_mem_address,
   input  logic [7:0]                          req_mem_data,
   input  logic [tpf_pkg::COORD_W-1:0]         req_query_x,
   input  logic [tpf_pkg::COORD_W-1:0]         req_query_y,
   input  logic                                rsp_valid,
   input  logic [tpf_pkg::COORD_W-1:0]         rsp_out_x,
   input  logic [tpf_pkg::COORD_W-1:0]         rsp_out_y,
   input  logic [tpf_pkg::PAL_W-1:0]           rsp_palette_line,
   input  logic [tpf_pkg::NIB_W-1:0]           rsp_color_index,
   input  logic                                rsp_opaque,
   input  logic                                rsp_in_range,
   output int                                  fail_count,
   output int                                  pending
);

   typedef struct packed {
      logic [tpf_pkg::COORD_W-1:0] x;
      logic [tpf_pkg::COORD_W-1:0] y;
      logic [tpf_pkg::PAL_W-1:0]   pal;
      logic [tpf_pkg::NIB_W-1:0]   nib;
      logic                        opaque;
      logic                        in_range;
   } pixel_type;

   logic [7:0]                 vram [MEM_BYTES];
   logic [tpf_pkg::BASE_W-1:0] plane_base;
   logic [tpf_pkg::SIZE_W-1:0] plane_w;
   logic [tpf_pkg::SIZE_W-1:0] plane_h;
   pixel_type                  pending_pixels [$];
   int                         mismatches = 0;

   assign fail_count = mismatches;
   assign pending    = pending_pixels.size();

   // name table entry -> tile byte -> nibble
   function automatic pixel_type fetch_pixel(input logic [tpf_pkg::COORD_W-1:0] x,
                                             input logic [tpf_pkg::COORD_W-1:0] y);
      int unsigned w, h, entry, tile_addr;
      logic [7:0]  hi, lo, tbyte;
      logic [10:0] tile;
      pixel_type   p;
      p = '0;
      p.x = x;
      p.y = y;
      w = plane_w;
      h = plane_h;
      if (x >= w * 8 || y >= h * 8) return p;
      entry = (int'(plane_base) + 2 * ((y >> 3) * w + (x >> 3))) % MEM_BYTES;
      hi = vram[entry];
      lo = vram[(entry + 1) % MEM_BYTES];
      tile = {hi[2:0], lo};
      tile_addr = (tile * 32 + (y % 8) * 4 + (x % 8) / 2) % MEM_BYTES;
      tbyte = vram[tile_addr];
      p.pal = hi[6:5];
      p.nib = x[0] ? tbyte[3:0] : tbyte[7:4];
      p.opaque = (p.nib != '0);
      p.in_range = 1'b1;
      return p;
   endfunction

   task automatic check_pixel(input pixel_type got);
      pixel_type want;
      if (pending_pixels.size() == 0) begin
         if (mismatches < 10)
            $display("pixel beat with nothing expected: x=%0d y=%0d pal=%0d nib=%0d",
                     got.x, got.y, got.pal, got.nib);
         mismatches++;
         return;
      end
      want = pending_pixels.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.pal !== want.pal ||
          got.nib !== want.nib || got.opaque !== want.opaque ||
          got.in_range !== want.in_range) begin
         if (mismatches < 10) begin
            $display("pixel mismatch: exp x=%0d y=%0d pal=%0d nib=%0d opq=%0b in=%0b",
                     want.x, want.y, want.pal, want.nib, want.opaque, want.in_range);
            $display("                got x=%0d y=%0d pal=%0d nib=%0d opq=%0b in=%0b",
                     got.x, got.y, got.pal, got.nib, got.opaque, got.in_range);
         end
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         plane_base <= tpf_pkg::TABLE_BASE_RESET;
         plane_w    <= tpf_pkg::WIDTH_TILES_RESET;
         plane_h    <= tpf_pkg::HEIGHT_TILES_RESET;
         pending_pixels.delete();
      end else begin
         if (rsp_valid)
            check_pixel({rsp_out_x, rsp_out_y, rsp_palette_line, rsp_color_index,
                         rsp_opaque, rsp_in_range});
         if (csr_write_en) begin
            case (csr_index)
               tpf_pkg::CSR_TABLE_BASE:
                  plane_base <= csr_write_data[tpf_pkg::BASE_W-1:0];
               tpf_pkg::CSR_WIDTH_TILES:
                  plane_w    <= csr_write_data[tpf_pkg::SIZE_W-1:0];
               tpf_pkg::CSR_HEIGHT_TILES:
                  plane_h    <= csr_write_data[tpf_pkg::SIZE_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_mode == tpf_pkg::MODE_QUERY)
               pending_pixels.push_back(fetch_pixel(req_query_x, req_query_y));
            else
               vram[int'(req_mem_address) % MEM_BYTES] <= req_mem_data;
         end
      end
   end

endmodule

[tb/sv/tb_top.sv]
module tb_top;

   localparam int unsigned VRAM_BYTES   = tpf_pkg::MEM_BYTES_DEFAULT;
   localparam int          CYCLE_LIMIT  = 300000;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          PHASES       = 6;
   localparam int          PHASE_BEATS  = 75;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_write_en = 1'b0;
   logic [tpf_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [tpf_pkg::CSR_DATA_W-1:0]  csr_write_data = '0;
   logic                            start = 1'b0;
   logic                            busy;
   logic                            req_mode = tpf_pkg::MODE_WRITE;
   logic [tpf_pkg::HOST_ADDR_W-1:0] req_mem_address = '0;
   logic [7:0]                      req_mem_data = '0;
   logic [tpf_pkg::COORD_W-1:0]     req_query_x = '0;
   logic [tpf_pkg::COORD_W-1:0]     req_query_y = '0;
   logic                            rsp_valid;
   logic [tpf_pkg::COORD_W-1:0]     rsp_out_x;
   logic [tpf_pkg::COORD_W-1:0]     rsp_out_y;
   logic [tpf_pkg::PAL_W-1:0]       rsp_palette_line;
   logic [tpf_pkg::NIB_W-1:0]       rsp_color_index;
   logic                            rsp_opaque;
   logic                            rsp_in_range;
   int                              fail_count;
   int                              pending;
   int                              cycle_count = 0;

   // stimulus-side image of video memory: only used to steer queries onto
   // bytes that have been written
   logic [7:0]                 vram_image [VRAM_BYTES];
   bit                         vram_known [VRAM_BYTES];
   logic [tpf_pkg::BASE_W-1:0] plane_base = tpf_pkg::TABLE_BASE_RESET;
   int unsigned                plane_w = tpf_pkg::WIDTH_TILES_RESET;
   int unsigned                plane_h = tpf_pkg::HEIGHT_TILES_RESET;
   bit                         quiet_run = 1'b0;   // no idle gaps while set
   int                         beats_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tilemap_plane_pixel_fetch dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_mem_address  (req_mem_address),
      .req_mem_data     (req_mem_data),
      .req_query_x      (req_query_x),
      .req_query_y      (req_query_y),
      .rsp_valid        (rsp_valid),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_palette_line (rsp_palette_line),
      .rsp_color_index  (rsp_color_index),
      .rsp_opaque       (rsp_opaque),
      .rsp_in_range     (rsp_in_range)
   );

   tpf_checker #(.MEM_BYTES(VRAM_BYTES)) pixel_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_mem_address  (req_mem_address),
      .req_mem_data     (req_mem_data),
      .req_query_x      (req_query_x),
      .req_query_y      (req_query_y),
      .rsp_valid        (rsp_valid),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_palette_line (rsp_palette_line),
      .rsp_color_index  (rsp_color_index),
      .rsp_opaque       (rsp_opaque),
      .rsp_in_range     (rsp_in_range),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL tilemap_plane_pixel_fetch");
         $finish;
      end
   end

   // One beat on the req_ side. Inputs move on the falling edge; the beat is
   // taken at the first rising edge that sees busy low. Unused fields carry
   // random data so every bit toggles.
   task automatic send_beat(input logic mode,
                            input logic [tpf_pkg::HOST_ADDR_W-1:0] addr,
                            input logic [7:0] data,
                            input logic [tpf_pkg::COORD_W-1:0] x,
                            input logic [tpf_pkg::COORD_W-1:0] y);
      int gap;
      gap = quiet_run ? 0 : $urandom_range(0, 4);
      repeat (gap) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      req_mode        = mode;
      req_mem_address = addr;
      req_mem_data    = data;
      req_query_x     = x;
      req_query_y     = y;
      start           = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      beats_sent++;
   endtask

   task automatic write_mem(input int unsigned addr, input logic [7:0] data);
      send_beat(tpf_pkg::MODE_WRITE, tpf_pkg::HOST_ADDR_W'(addr), data,
                tpf_pkg::COORD_W'($urandom), tpf_pkg::COORD_W'($urandom));
      vram_image[addr % VRAM_BYTES] = data;
      vram_known[addr % VRAM_BYTES] = 1'b1;
   endtask

   // tile bytes lean toward a zero nibble so transparent pixels show up often
   function automatic logic [7:0] pick_tile_byte();
      logic [7:0] b;
      b = 8'($urandom);
      case ($urandom_range(0, 3))
         0: b[7:4] = 4'h0;
         1: b[3:0] = 4'h0;
         default: ;
      endcase
      return b;
   endfunction

   task automatic fill_byte(input int unsigned addr);
      if (!vram_known[addr]) write_mem(addr, pick_tile_byte());
   endtask

   // Make sure every byte an in-range query reads has been written: both
   // bytes of the name table entry, then the tile byte it points to.
   task automatic make_readable(input int unsigned x, input int unsigned y);
      int unsigned entry, entry_lo, tile_addr;
      logic [10:0] tile;
      if (x >= plane_w * 8 || y >= plane_h * 8) return;
      entry    = (int'(plane_base) + 2 * ((y >> 3) * plane_w + (x >> 3))) % VRAM_BYTES;
      entry_lo = (entry + 1) % VRAM_BYTES;
      fill_byte(entry);
      fill_byte(entry_lo);
      tile      = {vram_image[entry][2:0], vram_image[entry_lo]};
      tile_addr = (tile * 32 + (y % 8) * 4 + (x % 8) / 2) % VRAM_BYTES;
      fill_byte(tile_addr);
   endtask

   task automatic query_pixel(input int unsigned x, input int unsigned y);
      make_readable(x, y);
      send_beat(tpf_pkg::MODE_QUERY, tpf_pkg::HOST_ADDR_W'($urandom), 8'($urandom),
                tpf_pkg::COORD_W'(x), tpf_pkg::COORD_W'(y));
   endtask

   // sender stops until every pixel beat is back and the pipeline is empty
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [tpf_pkg::CSR_INDEX_W-1:0] index,
                            input logic [tpf_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en   = 1'b1;
      csr_index      = index;
      csr_write_data = data;
      @(negedge clock);
      csr_write_en   = 1'b0;
   endtask

   // Size registers are 8 bits; junk in the upper byte must be dropped.
   task automatic set_plane(input logic [tpf_pkg::BASE_W-1:0] base,
                            input int unsigned w, input int unsigned h);
      logic [7:0] junk;
      drain();
      write_csr(tpf_pkg::CSR_TABLE_BASE, base);
      junk = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
      write_csr(tpf_pkg::CSR_WIDTH_TILES, {junk, 8'(w)});
      junk = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
      write_csr(tpf_pkg::CSR_HEIGHT_TILES, {junk, 8'(h)});
      plane_base = base;
      plane_w    = w & 8'hFF;
      plane_h    = h & 8'hFF;
   endtask

   // zero, in-range, and above-range sizes (up to 255 is used as given)
   function automatic int unsigned pick_size();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 255;
         2: return $urandom_range(129, 254);
         3: return 128;
         4: return 1;
         default: return $urandom_range(1, 24);
      endcase
   endfunction

   function automatic logic [tpf_pkg::BASE_W-1:0] pick_base();
      case ($urandom_range(0, 3))
         0: return '1;
         1: return '0;
         default: return tpf_pkg::BASE_W'($urandom);
      endcase
   endfunction

   // coordinate inside the plane when the plane has any pixels
   function automatic int unsigned pick_coord(input int unsigned tiles);
      int unsigned top_px;
      if (tiles == 0) return $urandom_range(0, 1023);
      top_px = tiles * 8 - 1;
      if (top_px > 1023) top_px = 1023;
      return $urandom_range(0, top_px);
   endfunction

   initial begin
      int phase_start;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // ---- directed, reset plane: base 0, 64 x 32 cells ----
      // cell 0 entry 0xFFFF: priority and flips set, palette 3, tile 2047
      write_mem(16'h0000, 8'hFF);
      write_mem(16'h0001, 8'hFF);
      // tile 2047 row 0: even column opaque, odd column transparent
      write_mem(16'hFFE0, 8'hA0);
      query_pixel(0, 0);
      query_pixel(1, 0);
      write_mem(16'hFFFF, 8'h00);            // top address, all-zero data
      query_pixel(511, 255);                 // last pixel inside
      query_pixel(512, 0);                   // just right of the plane
      query_pixel(0, 256);                   // just below the plane
      query_pixel(1023, 1023);

      // entry at the last address: its second byte wraps to address 0
      set_plane(16'hFFFF, 128, 128);
      query_pixel(0, 0);
      query_pixel(1023, 1023);

      // zero-sized planes put every pixel outside
      set_plane(tpf_pkg::BASE_W'($urandom), 0, 5);
      query_pixel(0, 0);
      set_plane(tpf_pkg::BASE_W'($urandom), 7, 0);
      query_pixel(3, 0);

      // sizes above the nominal range; the table wraps around memory
      set_plane(16'h1234, 255, 255);
      query_pixel(1023, 1023);
      query_pixel(7, 9);

      // single-cell plane
      set_plane(16'h8000, 1, 1);
      query_pixel(7, 7);
      query_pixel(8, 0);
      query_pixel(0, 8);

      // ---- random phases: mostly well-formed fetches, some noise ----
      for (int phase = 0; phase < PHASES; phase++) begin
         set_plane(pick_base(), pick_size(), pick_size());
         quiet_run   = ($urandom_range(0, 2) == 0);
         phase_start = beats_sent;
         while (beats_sent - phase_start < PHASE_BEATS) begin
            if ($urandom_range(0, 15) == 0) quiet_run = !quiet_run;
            if ($urandom_range(0, 49) == 0) drain();
            case ($urandom_range(0, 9))
               0, 1: write_mem($urandom_range(0, VRAM_BYTES - 1), 8'($urandom));
               2:    query_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
               default: query_pixel(pick_coord(plane_w), pick_coord(plane_h));
            endcase
         end
      end

      drain();
      if (fail_count == 0)
         $display("PASS tilemap_plane_pixel_fetch");
      else
         $display("FAIL tilemap_plane_pixel_fetch");
      $finish;
   end

endmodule

[tilemap_plane_pixel_fetch.f]
hdl/tpf_pkg.sv
hdl/tilemap_plane_pixel_fetch.sv
tb/sv/tpf_checker.sv
tb/sv/tb_top.sv
